[sv/utf8vd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared status codes, result and record types, and decode constants.
// ----------------------------------------------------------------------------
package utf8vd_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_LEAD     = 3'd2,
        ST_STRAY    = 3'd3,
        ST_RANGE    = 3'd4,
        ST_OVERLONG = 3'd5,
        ST_TRUNC    = 3'd6
    } status_t;

    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] SUR_LO  = 21'h00D800;
    localparam logic [20:0] SUR_HI  = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN2 = 21'h000080;
    localparam logic [20:0] MIN_LEN3 = 21'h000800;
    localparam logic [20:0] MIN_LEN4 = 21'h010000;
    localparam logic [7:0]  BAD_BYTE_MIN = 8'd254;

    typedef struct packed {
        logic [20:0] code_point;
        status_t     status;
        logic        run_last;
        logic        text_done;
    } result_t;

    // All results caused by one input byte: one, or two when two_res is set.
    typedef struct packed {
        logic    two_res;
        result_t res0;
        result_t res1;
    } record_t;

    // Builds a result; the code point is forced to zero on any failure.
    function automatic result_t make_result(logic [20:0] cp, status_t st);
        result_t r;
        r.code_point = (st == ST_OK) ? cp : 21'd0;
        r.status     = st;
        r.run_last   = 1'b0;
        r.text_done  = 1'b0;
        return r;
    endfunction

endpackage

[sv/utf8vd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Classifies each byte, tracks the open sequence and forms its result record.
// ----------------------------------------------------------------------------
module utf8vd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    output logic                rec_push,
    output utf8vd_pkg::record_t rec
);

    logic [2:0]  remain_reg, remain_next;
    logic [2:0]  len_reg, len_next;
    logic [20:0] acc_reg, acc_next;

    utf8vd_pkg::result_t res [2];
    logic [1:0]          n;

    // Checks a completed value against its sequence length and the scalar range.
    function automatic utf8vd_pkg::status_t judge(logic [20:0] v, logic [2:0] len);
        utf8vd_pkg::status_t st;
        st = utf8vd_pkg::ST_OK;
        if (len >= 3'd5)
            st = utf8vd_pkg::ST_OVERLONG;
        else if ((v >= utf8vd_pkg::SUR_LO && v <= utf8vd_pkg::SUR_HI) ||
                 v > utf8vd_pkg::CP_MAX)
            st = utf8vd_pkg::ST_RANGE;
        else if ((len == 3'd2 && v < utf8vd_pkg::MIN_LEN2) ||
                 (len == 3'd3 && v < utf8vd_pkg::MIN_LEN3) ||
                 (len == 3'd4 && v < utf8vd_pkg::MIN_LEN4))
            st = utf8vd_pkg::ST_OVERLONG;
        return st;
    endfunction

    always_comb
    begin
        logic [20:0] shifted;
        remain_next = remain_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        res[0]      = utf8vd_pkg::make_result(21'd0, utf8vd_pkg::ST_OK);
        res[1]      = res[0];
        n           = 2'd0;
        shifted     = {acc_reg[14:0], text_byte[5:0]};

        if (text_byte >= utf8vd_pkg::BAD_BYTE_MIN) begin
            remain_next = 3'd0;
            len_next    = 3'd0;
            acc_next    = 21'd0;
            res[0]      = utf8vd_pkg::make_result(21'd0, utf8vd_pkg::ST_INVALID);
            n           = 2'd1;
        end else if (text_byte[7:6] != 2'b10) begin
            if (remain_reg != 3'd0) begin
                remain_next = 3'd0;
                len_next    = 3'd0;
                acc_next    = 21'd0;
                res[0]      = utf8vd_pkg::make_result(21'd0, utf8vd_pkg::ST_LEAD);
                n           = 2'd1;
            end
            if (text_byte < 8'hC0) begin
                res[n[0]] = utf8vd_pkg::make_result({13'd0, text_byte},
                                                    utf8vd_pkg::ST_OK);
                n         = n + 2'd1;
            end else if (text_byte inside {[8'hC0:8'hDF]}) begin
                acc_next = {16'd0, text_byte[4:0]};
                len_next = 3'd2;
                remain_next = 3'd1;
            end else if (text_byte inside {[8'hE0:8'hEF]}) begin
                acc_next = {17'd0, text_byte[3:0]};
                len_next = 3'd3;
                remain_next = 3'd2;
            end else if (text_byte inside {[8'hF0:8'hF7]}) begin
                acc_next = {18'd0, text_byte[2:0]};
                len_next = 3'd4;
                remain_next = 3'd3;
            end else if (text_byte inside {[8'hF8:8'hFB]}) begin
                acc_next = {19'd0, text_byte[1:0]};
                len_next = 3'd5;
                remain_next = 3'd4;
            end else begin
                acc_next = {20'd0, text_byte[0]};
                len_next = 3'd6;
                remain_next = 3'd5;
            end
        end else if (remain_reg != 3'd0) begin
            acc_next    = shifted;
            remain_next = remain_reg - 3'd1;
            if (remain_reg == 3'd1) begin
                res[0]      = utf8vd_pkg::make_result(shifted, judge(shifted, len_reg));
                n           = 2'd1;
                len_next    = 3'd0;
                acc_next    = 21'd0;
            end
        end else begin
            res[0] = utf8vd_pkg::make_result(21'd0, utf8vd_pkg::ST_STRAY);
            n      = 2'd1;
        end

        if (end_of_text) begin
            if (remain_next != 3'd0) begin
                res[n[0]] = utf8vd_pkg::make_result(21'd0, utf8vd_pkg::ST_TRUNC);
                n         = n + 2'd1;
            end
            remain_next = 3'd0;
            len_next    = 3'd0;
            acc_next    = 21'd0;
        end

        if (n == 2'd2) begin
            res[1].run_last  = 1'b1;
            res[1].text_done = end_of_text;
        end else begin
            res[0].run_last  = 1'b1;
            res[0].text_done = end_of_text;
        end
    end

    assign rec.two_res = (n == 2'd2);
    assign rec.res0    = res[0];
    assign rec.res1    = res[1];
    assign rec_push    = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            remain_reg <= 3'd0;
            len_reg    <= 3'd0;
            acc_reg    <= 21'd0;
        end else if (accept) begin
            remain_reg <= remain_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

[sv/utf8vd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder record queue
// Small first-in first-out buffer of result records between front and back.
// ----------------------------------------------------------------------------
module utf8vd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  utf8vd_pkg::record_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output utf8vd_pkg::record_t rd_data,
    output logic                not_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    utf8vd_pkg::record_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[sv/utf8vd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Splits records into single results and holds the output register.
// ----------------------------------------------------------------------------
module utf8vd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_avail,
    input  utf8vd_pkg::record_t rec,
    output logic                rec_pop,
    input  logic                pop,
    output logic                empty,
    output utf8vd_pkg::result_t res
);

    logic                out_valid_reg, out_valid_next;
    utf8vd_pkg::result_t out_reg, out_next;
    logic                sec_valid_reg, sec_valid_next;
    utf8vd_pkg::result_t sec_reg, sec_next;
    logic                out_free;

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign res      = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sec_valid_next = sec_valid_reg;
        sec_next       = sec_reg;
        rec_pop        = 1'b0;
        if (out_free) begin
            if (sec_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = sec_reg;
                sec_valid_next = 1'b0;
            end else if (rec_avail) begin
                rec_pop        = 1'b1;
                out_valid_next = 1'b1;
                out_next       = rec.res0;
                sec_valid_next = rec.two_res;
                sec_next       = rec.res1;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sec_reg <= sec_next;
    end

endmodule

[sv/utf8_validating_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Turns a UTF-8 byte stream into Unicode scalar values with a status per result.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ----------------------------------------------
//  input     push / full          text_byte[7:0], end_of_text
//  result    pop / empty          code_point[20:0], status[2:0], run_last,
//                                 text_done
//
// One byte is taken per cycle while the record queue has room. With the output
// side idle, a byte's record is written to the queue and then loaded into the
// output register; results leave at one beat per cycle while pop is held.
// Reset is asynchronous and active low; it closes any open sequence and
// empties the record queue and the output register.
// A stalled result side fills the QUEUE_DEPTH-record queue, then full rises.
//
module utf8_validating_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] code_point,
    output logic [2:0]  status,
    output logic        run_last,
    output logic        text_done
);

    logic                accept;
    logic                rec_push;
    utf8vd_pkg::record_t rec_in;
    utf8vd_pkg::record_t rec_out;
    logic                rec_avail;
    logic                rec_pop;
    utf8vd_pkg::result_t res;

    // A beat is taken whenever push is high and the queue has room; bytes that
    // cause no result only update the sequence state and never enter the queue.
    assign accept = push && !full;

    utf8vd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    utf8vd_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (rec_in),
        .full      (full),
        .rd_en     (rec_pop),
        .rd_data   (rec_out),
        .not_empty (rec_avail)
    );

    utf8vd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (rec_avail),
        .rec       (rec_out),
        .rec_pop   (rec_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    // The output register holds one complete result for each beat.
    assign code_point = res.code_point;
    assign status     = res.status;
    assign run_last   = res.run_last;
    assign text_done  = res.text_done;

endmodule
